### hw/rtl/ufmt_pkg.sv
// Shared types and constants for the unsigned decimal field formatter.
`default_nettype none
package ufmt_pkg;

    localparam int MAX_FIELD_DEF = 63;
    localparam int VAL_W         = 32;
    localparam int DIGITS        = 10;
    localparam int BCD_W         = 4 * DIGITS;
    localparam int LEN_W         = 4;
    localparam int CNT_W         = $clog2(VAL_W);

    localparam logic [1:0] PAD_LEFT = 2'd1;
    localparam logic [1:0] PAD_ZERO = 2'd2;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_ZERO  = 7'h30;

    typedef enum logic [1:0] {
        BCD_IDLE,
        BCD_SHIFT,
        BCD_NORM,
        BCD_DONE
    } t_bcd_state;

    typedef enum logic [2:0] {
        E_IDLE,
        E_WAIT,
        E_PLAN,
        E_SIZE,
        E_OUT
    } t_emit_state;

    typedef struct packed {
        logic              done;
        logic [LEN_W-1:0]  len;
        logic [BCD_W-1:0]  digits;
    } t_bcd_res;

endpackage
`default_nettype wire

### hw/rtl/ufmt_bcd.sv
// Bit-serial binary to BCD converter with leading-zero digit removal.
`default_nettype none
module ufmt_bcd (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ufmt_pkg::VAL_W-1:0]    i_value,
    output      logic                          o_busy,
    output      ufmt_pkg::t_bcd_res            o_res
);

    ufmt_pkg::t_bcd_state r_state, n_state;

    logic [ufmt_pkg::VAL_W-1:0] r_bin, n_bin;
    logic [ufmt_pkg::BCD_W-1:0] r_bcd, n_bcd;
    logic [ufmt_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [ufmt_pkg::LEN_W-1:0] r_len, n_len;
    logic [ufmt_pkg::BCD_W-1:0] adj;
    logic                       top_zero;

    always_comb begin
        for (int d = 0; d < ufmt_pkg::DIGITS; d++) begin
            adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                      : r_bcd[4*d +: 4];
        end
    end

    assign top_zero = (r_bcd[ufmt_pkg::BCD_W-1 -: 4] == 4'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ufmt_pkg::BCD_IDLE: begin
                if (i_start) n_state = ufmt_pkg::BCD_SHIFT;
            end
            ufmt_pkg::BCD_SHIFT: begin
                if (r_cnt == ufmt_pkg::CNT_W'(ufmt_pkg::VAL_W - 1)) begin
                    n_state = ufmt_pkg::BCD_NORM;
                end
            end
            ufmt_pkg::BCD_NORM: begin
                if (!(top_zero && r_len > ufmt_pkg::LEN_W'(1))) begin
                    n_state = ufmt_pkg::BCD_DONE;
                end
            end
            ufmt_pkg::BCD_DONE: n_state = ufmt_pkg::BCD_IDLE;
            default:            n_state = ufmt_pkg::BCD_IDLE;
        endcase
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        n_len = r_len;
        unique case (r_state)
            ufmt_pkg::BCD_IDLE: begin
                n_bin = i_value;
                n_bcd = '0;
                n_cnt = '0;
                n_len = ufmt_pkg::LEN_W'(ufmt_pkg::DIGITS);
            end
            ufmt_pkg::BCD_SHIFT: begin
                n_bcd = {adj[ufmt_pkg::BCD_W-2:0], r_bin[ufmt_pkg::VAL_W-1]};
                n_bin = {r_bin[ufmt_pkg::VAL_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
            end
            ufmt_pkg::BCD_NORM: begin
                if (top_zero && r_len > ufmt_pkg::LEN_W'(1)) begin
                    n_bcd = {r_bcd[ufmt_pkg::BCD_W-5:0], 4'd0};
                    n_len = r_len - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ufmt_pkg::BCD_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_len <= n_len;
    end

    assign o_busy       = (r_state != ufmt_pkg::BCD_IDLE);
    assign o_res.done   = (r_state == ufmt_pkg::BCD_DONE);
    assign o_res.len    = r_len;
    assign o_res.digits = r_bcd;

endmodule
`default_nettype wire

### hw/rtl/ufmt_emit.sv
// Field planner and character sequencer: fill, leading zeros, digits, trailing fill.
`default_nettype none
module ufmt_emit #(
    parameter int MAX_FIELD = ufmt_pkg::MAX_FIELD_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [5:0]         i_field_width,
    input  wire logic signed [6:0]  i_precision,
    input  wire logic [1:0]         i_pad_mode,
    input  wire ufmt_pkg::t_bcd_res i_bcd,
    output      logic               o_busy,
    output      logic               o_valid,
    output      logic [6:0]         o_character,
    output      logic               o_last
);

    localparam int CW = $clog2(MAX_FIELD + 1);

    ufmt_pkg::t_emit_state r_state, n_state;

    logic [CW-1:0]              r_width, n_width;
    logic [CW-1:0]              r_target, n_target;
    logic                       r_left, n_left;
    logic [ufmt_pkg::LEN_W-1:0] r_len, n_len;
    logic [ufmt_pkg::BCD_W-1:0] r_digits, n_digits;
    logic [CW-1:0]              r_zeros, n_zeros;
    logic [CW-1:0]              r_lead, n_lead;
    logic [CW-1:0]              r_trail, n_trail;
    logic [CW-1:0]              r_rem, n_rem;

    logic                       has_prec;
    logic [7:0]                 max8, w8, p8, wcl8, pcl8;
    logic [CW-1:0]              len_x, zl, fill;

    assign has_prec = !i_precision[6];
    assign max8     = 8'(MAX_FIELD);
    assign w8       = {2'b00, i_field_width};
    assign p8       = has_prec ? {2'b00, i_precision[5:0]} : 8'd0;
    assign wcl8     = (w8 > max8) ? max8 : w8;
    assign pcl8     = (p8 > max8) ? max8 : p8;

    assign len_x = CW'(r_len);
    assign zl    = r_zeros + len_x;
    assign fill  = (r_width > zl) ? r_width - zl : '0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ufmt_pkg::E_IDLE: if (i_start)    n_state = ufmt_pkg::E_WAIT;
            ufmt_pkg::E_WAIT: if (i_bcd.done) n_state = ufmt_pkg::E_PLAN;
            ufmt_pkg::E_PLAN:                 n_state = ufmt_pkg::E_SIZE;
            ufmt_pkg::E_SIZE:                 n_state = ufmt_pkg::E_OUT;
            ufmt_pkg::E_OUT: begin
                if (r_rem == CW'(1)) n_state = ufmt_pkg::E_IDLE;
            end
            default:                          n_state = ufmt_pkg::E_IDLE;
        endcase
    end

    always_comb begin
        n_width  = r_width;
        n_target = r_target;
        n_left   = r_left;
        n_len    = r_len;
        n_digits = r_digits;
        n_zeros  = r_zeros;
        n_lead   = r_lead;
        n_trail  = r_trail;
        n_rem    = r_rem;
        unique case (r_state)
            ufmt_pkg::E_IDLE: begin
                n_width  = wcl8[CW-1:0];
                n_target = (i_pad_mode == ufmt_pkg::PAD_ZERO && !has_prec) ? wcl8[CW-1:0]
                                                                           : pcl8[CW-1:0];
                n_left   = (i_pad_mode == ufmt_pkg::PAD_LEFT);
            end
            ufmt_pkg::E_WAIT: begin
                n_len    = i_bcd.len;
                n_digits = i_bcd.digits;
            end
            ufmt_pkg::E_PLAN: begin
                n_zeros = (r_target > len_x) ? r_target - len_x : '0;
            end
            ufmt_pkg::E_SIZE: begin
                n_lead  = r_left ? '0 : fill;
                n_trail = r_left ? fill : '0;
                n_rem   = zl + fill;
            end
            ufmt_pkg::E_OUT: begin
                n_rem = r_rem - 1'b1;
                priority if (r_lead != '0) begin
                    n_lead = r_lead - 1'b1;
                end else if (r_zeros != '0) begin
                    n_zeros = r_zeros - 1'b1;
                end else if (r_len != '0) begin
                    n_len    = r_len - 1'b1;
                    n_digits = {r_digits[ufmt_pkg::BCD_W-5:0], 4'd0};
                end else if (r_trail != '0) begin
                    n_trail = r_trail - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_valid = (r_state == ufmt_pkg::E_OUT);
        o_last  = o_valid && (r_rem == CW'(1));
        priority if (r_lead != '0) begin
            o_character = ufmt_pkg::CH_SPACE;
        end else if (r_zeros != '0) begin
            o_character = ufmt_pkg::CH_ZERO;
        end else if (r_len != '0) begin
            o_character = ufmt_pkg::CH_ZERO | {3'b000, r_digits[ufmt_pkg::BCD_W-1 -: 4]};
        end else begin
            o_character = ufmt_pkg::CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ufmt_pkg::E_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_width  <= n_width;
        r_target <= n_target;
        r_left   <= n_left;
        r_len    <= n_len;
        r_digits <= n_digits;
        r_zeros  <= n_zeros;
        r_lead   <= n_lead;
        r_trail  <= n_trail;
        r_rem    <= n_rem;
    end

    assign o_busy = (r_state != ufmt_pkg::E_IDLE);

endmodule
`default_nettype wire

### hw/rtl/unsigned_decimal_field_formatter_core.sv
// Accept to first character: 32 conversion bits, up to 9 leading-zero digit skips, then plan and size.
// Then one character per cycle for the whole field, up to MAX_FIELD characters, last marked.
// One item at a time: busy stays high from accept through the last character of the field.
// The next item is accepted in the cycle after the last character; the receiver cannot stall.
// Reset: synchronous, active low; returns both sequencers to idle, data registers are not reset.
`default_nettype none
module unsigned_decimal_field_formatter_core #(
    parameter int MAX_FIELD = ufmt_pkg::MAX_FIELD_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output      logic                       busy,
    input  wire logic [ufmt_pkg::VAL_W-1:0] i_value,
    input  wire logic [5:0]                 i_field_width,
    input  wire logic signed [6:0]          i_precision,
    input  wire logic [1:0]                 i_pad_mode,
    output      logic                       o_valid,
    output      logic [6:0]                 o_character,
    output      logic                       o_last
);

    ufmt_pkg::t_bcd_res bcd_res;
    logic               bcd_busy;
    logic               emit_busy;
    logic               accept;

    assign accept = start && !busy;
    assign busy   = bcd_busy || emit_busy;

    ufmt_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_value (i_value),
        .o_busy  (bcd_busy),
        .o_res   (bcd_res)
    );

    ufmt_emit #(
        .MAX_FIELD (MAX_FIELD)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept),
        .i_field_width (i_field_width),
        .i_precision   (i_precision),
        .i_pad_mode    (i_pad_mode),
        .i_bcd         (bcd_res),
        .o_busy        (emit_busy),
        .o_valid       (o_valid),
        .o_character   (o_character),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

### hw/rtl/ufmt_checker.sv
// Port-level checker for the formatter core, bound to the top level.
`default_nettype none
module ufmt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic [6:0] o_character,
    input wire logic       o_last
);

    a_valid_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("character shown while not busy");

    a_last_has_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last without character");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted item did not raise busy");

    a_field_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap inside a field");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == 7'h20 ||
                     (o_character >= 7'h30 && o_character <= 7'h39)))
        else $error("character outside space and digits");

endmodule

bind unsigned_decimal_field_formatter_core ufmt_checker u_ufmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_character (o_character),
    .o_last      (o_last)
);
`default_nettype wire
